FILE: src/rrts_pkg.sv
// Shared types and constants for the round-robin task switcher.
`default_nettype none

package rrts_pkg;

	localparam int unsigned SLOT_COUNT_DEFAULT  = 8;
	localparam int unsigned STACK_BYTES_DEFAULT = 1024;
	localparam logic [31:0] STACK_BASE_RESET    = 32'h2000_0000;
	localparam logic [31:0] WORD_BYTES          = 32'd4;

	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_START    = 2'd1;
	localparam logic [1:0] OP_SCHEDULE = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  task_slot;
		logic [31:0] entry_address;
		logic [31:0] outgoing_stack_pointer;
	} rrts_in_t;

	typedef struct packed {
		logic [31:0] resume_stack_pointer;
		logic [31:0] launch_address;
		logic        found;
		logic [2:0]  running_slot;
	} rrts_out_t;

	// Write and read strobes toward the slot memories.
	typedef struct packed {
		logic sp_we;
		logic entry_we;
		logic rd_en;
	} rrts_mem_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SRCH,
		ST_READ,
		ST_RESP
	} rrts_state_t;

endpackage

`default_nettype wire

FILE: src/rrts_slot_mem.sv
// Slot memories: saved stack pointers and start addresses, one read port.
`default_nettype none

module rrts_slot_mem #(
	parameter int unsigned SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEFAULT
) (
	input  wire                              clk,
	input  wire rrts_pkg::rrts_mem_ctl_t     ctl,
	input  wire [$clog2(SLOT_COUNT)-1:0]     sp_wr_addr,
	input  wire [31:0]                       sp_wr_data,
	input  wire [$clog2(SLOT_COUNT)-1:0]     entry_wr_addr,
	input  wire [31:0]                       entry_wr_data,
	input  wire [$clog2(SLOT_COUNT)-1:0]     rd_addr,
	output logic [31:0]                      rd_sp,
	output logic [31:0]                      rd_entry
);
	import rrts_pkg::*;

	logic [31:0] sp_mem    [SLOT_COUNT];
	logic [31:0] entry_mem [SLOT_COUNT];

	always_ff @(posedge clk) begin
		if (ctl.sp_we) begin
			sp_mem[sp_wr_addr] <= sp_wr_data;
		end
		if (ctl.rd_en) begin
			rd_sp <= sp_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.entry_we) begin
			entry_mem[entry_wr_addr] <= entry_wr_data;
		end
		if (ctl.rd_en) begin
			rd_entry <= entry_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: src/rrts_picker.sv
// Round-robin pick of the next enabled slot after the current one.
`default_nettype none

module rrts_picker #(
	parameter int unsigned SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEFAULT
) (
	input  wire [SLOT_COUNT-1:0]             enabled,
	input  wire [$clog2(SLOT_COUNT)-1:0]     current,
	output logic [$clog2(SLOT_COUNT)-1:0]    next_slot,
	output logic                             any
);
	import rrts_pkg::*;

	localparam int unsigned SW = $clog2(SLOT_COUNT);

	logic [SW-1:0] hi_idx;
	logic [SW-1:0] lo_idx;
	logic          hi_any;
	logic          lo_any;

	// Scan downward so the lowest qualifying index wins.
	always_comb begin
		hi_idx = '0;
		lo_idx = '0;
		hi_any = 1'b0;
		lo_any = 1'b0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (enabled[i]) begin
				lo_idx = SW'(i);
				lo_any = 1'b1;
				if (SW'(i) > current) begin
					hi_idx = SW'(i);
					hi_any = 1'b1;
				end
			end
		end
	end

	// Prefer slots above the current one; wrap to the lowest otherwise.
	assign next_slot = hi_any ? hi_idx : lo_idx;
	assign any       = lo_any;

endmodule

`default_nettype wire

FILE: src/round_robin_task_switcher.sv
// Top level of the round-robin task switcher: sequencer, flags and result register.
`default_nettype none

// Keeps SLOT_COUNT task slots; the saved stack pointers and start addresses
// live in two synchronous memories, while the enable, first-run and
// pointer-saved bits sit in flip-flops that reset sets up at once (enable
// and pointer-saved cleared, first-run set), so no clearing pass is needed
// after reset. An add item (op 0) writes the start address memory in the
// cycle of its transfer and the next item may follow right away; it gives
// no result. A start (op 1) or schedule (op 2) item walks a four-step
// sequence: transfer (a schedule writes the outgoing pointer into the
// current slot here), search (round-robin over the enable bits for a
// schedule, slot zero for a start), memory read, and result assembly into
// the output register. No new item is taken until such an item has left
// the result assembly step; the memory read step covers the memory's read
// latency. A slot whose pointer was never saved reports the top of its
// stack computed from the present stack_base, so writing stack_base later
// still moves those slots. The result waits in its register for the
// downstream transfer; only the result assembly step stalls on it. Op code
// 3 is transferred and dropped. The configuration port is always ready and
// must only be written while the block is idle.

module round_robin_task_switcher #(
	parameter int unsigned SLOT_COUNT  = rrts_pkg::SLOT_COUNT_DEFAULT,
	parameter int unsigned STACK_BYTES = rrts_pkg::STACK_BYTES_DEFAULT
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire rrts_pkg::rrts_in_t  in_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output rrts_pkg::rrts_out_t   out_data,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire [31:0]            cfg_data
);
	import rrts_pkg::*;

	localparam int unsigned SW = $clog2(SLOT_COUNT);

	// Sequencer state and architectural flags.
	rrts_state_t       state_q, state_d;
	logic [31:0]       base_q;
	logic [SW-1:0]     cur_q;
	logic [SLOT_COUNT-1:0] en_q;
	logic [SLOT_COUNT-1:0] first_q;
	logic [SLOT_COUNT-1:0] saved_q;

	// Pipeline of one start/schedule item.
	logic              start_s1;
	logic [31:0]       outgoing_s1;
	logic [SW-1:0]     cand_s2;
	logic              found_s2;
	logic [31:0]       offset_s3;

	// Output register.
	logic              out_valid_q;
	rrts_out_t         out_q;

	// Handshake and decode.
	logic              in_xfer;
	logic              out_free;
	logic              load_out;
	logic [31:0]       slot_ext;
	logic              slot_ok;
	logic              is_add;
	logic              is_start;
	logic              is_sched;

	// Picker and memory.
	logic [SW-1:0]     pick_slot;
	logic              pick_any;
	rrts_mem_ctl_t     mem_ctl;
	logic [31:0]       rd_sp;
	logic [31:0]       rd_entry;

	// Result assembly.
	logic [31:0]       cand_ext;
	logic [31:0]       cur_ext;
	logic [31:0]       top_sp;
	logic [31:0]       res_sp;
	rrts_out_t         res;

	assign cfg_ready = 1'b1;

	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign slot_ext = 32'(in_data.task_slot);
	assign slot_ok  = slot_ext < 32'(SLOT_COUNT);
	assign is_add   = in_data.op == OP_ADD;
	assign is_start = in_data.op == OP_START;
	assign is_sched = in_data.op == OP_SCHEDULE;

	rrts_picker #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_picker (
		.enabled   (en_q),
		.current   (cur_q),
		.next_slot (pick_slot),
		.any       (pick_any)
	);

	rrts_slot_mem #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_slot_mem (
		.clk           (clk),
		.ctl           (mem_ctl),
		.sp_wr_addr    (cur_q),
		.sp_wr_data    (in_data.outgoing_stack_pointer),
		.entry_wr_addr (slot_ext[SW-1:0]),
		.entry_wr_data (in_data.entry_address),
		.rd_addr       (cand_s2),
		.rd_sp         (rd_sp),
		.rd_entry      (rd_entry)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && (is_start || is_sched)) begin
					state_d = ST_SRCH;
				end
			end
			ST_SRCH: state_d = ST_READ;
			ST_READ: state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready         = 1'b0;
		mem_ctl.sp_we    = 1'b0;
		mem_ctl.entry_we = 1'b0;
		mem_ctl.rd_en    = 1'b0;
		load_out         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready         = 1'b1;
				mem_ctl.sp_we    = in_valid && is_sched;
				mem_ctl.entry_we = in_valid && is_add && slot_ok;
			end
			ST_READ: mem_ctl.rd_en = 1'b1;
			ST_RESP: load_out = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= STACK_BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	// Flags: add enables and re-arms a slot, schedule marks the pointer saved,
	// result assembly of a start or a found slot moves the current slot and clears its first-run bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			en_q    <= '0;
			first_q <= '1;
			saved_q <= '0;
		end else begin
			if (in_xfer && is_add && slot_ok) begin
				en_q[slot_ext[SW-1:0]]    <= 1'b1;
				first_q[slot_ext[SW-1:0]] <= 1'b1;
			end
			if (in_xfer && is_sched) begin
				saved_q[cur_q] <= 1'b1;
			end
			if (load_out && found_s2) begin
				cur_q            <= cand_s2;
				first_q[cand_s2] <= 1'b0;
			end else if (load_out && start_s1) begin
				cur_q      <= '0;
				first_q[0] <= 1'b0;
			end
		end
	end

	// Hold the item's kind and outgoing pointer through the sequence.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			start_s1    <= is_start;
			outgoing_s1 <= in_data.outgoing_stack_pointer;
		end
	end

	// Search: start always targets slot zero; schedule takes the picker's slot.
	always_ff @(posedge clk) begin
		if (state_q == ST_SRCH) begin
			cand_s2  <= start_s1 ? '0 : pick_slot;
			found_s2 <= start_s1 ? 1'b0 : pick_any;
		end
	end

	// Offset of the candidate's stack top from stack_base.
	assign cand_ext = 32'(cand_s2);
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			offset_s3 <= (cand_ext + 32'd1) * 32'(STACK_BYTES) - WORD_BYTES;
		end
	end

	assign top_sp = base_q + offset_s3;
	assign res_sp = saved_q[cand_s2] ? rd_sp : top_sp;
	assign cur_ext = 32'(cur_q);

	always_comb begin
		res.resume_stack_pointer = res_sp;
		res.launch_address       = '0;
		res.found                = 1'b0;
		res.running_slot         = cur_ext[2:0];
		if (start_s1) begin
			// Entry memory counts as zero until the slot was added.
			res.launch_address = en_q[0] ? rd_entry : '0;
			res.found          = en_q[0];
			res.running_slot   = 3'd0;
		end else if (found_s2) begin
			res.launch_address = first_q[cand_s2] ? rd_entry : '0;
			res.found          = 1'b1;
			res.running_slot   = cand_ext[2:0];
		end else begin
			// Nothing enabled: echo the outgoing pointer, keep the current slot.
			res.resume_stack_pointer = outgoing_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire
